[rtl/ccas_pkg.sv]
`default_nettype none
package ccas_pkg;

    // command codes
    typedef enum logic [1:0] {
        CMD_WRITE   = 2'd0,
        CMD_READ    = 2'd1,
        CMD_ADVANCE = 2'd2,
        CMD_NOP     = 2'd3
    } ccas_cmd_t;

    // configuration register indexes
    typedef enum logic [1:0] {
        REG_RANGE     = 2'd0,
        REG_THRESHOLD = 2'd1,
        REG_COUNT     = 2'd2,
        REG_KIND      = 2'd3
    } ccas_reg_t;

    localparam int CFG_DATA_W = 6;

    typedef struct packed {
        logic [1:0] range;
        logic [5:0] threshold;
        logic [4:0] count;
        logic       kind;
    } ccas_cfg_t;

endpackage
`default_nettype wire

[rtl/ccas_cell.sv]
`default_nettype none
// One window cell: holds a state, passes it on, flags a successor match.
module ccas_cell #(
    parameter int STATE_BITS = 4
) (
    input  wire logic                  clk,
    input  wire logic                  shift,
    input  wire logic [STATE_BITS-1:0] d,
    input  wire logic [STATE_BITS-1:0] succ,
    input  wire logic                  en,
    output logic      [STATE_BITS-1:0] q,
    output logic                       hit
);

    logic [STATE_BITS-1:0] q_reg;

    always_ff @(posedge clk)
    begin
        if (shift)
        begin
            q_reg <= d;
        end
    end

    assign q   = q_reg;
    assign hit = en && (q_reg == succ);

endmodule
`default_nettype wire

[rtl/ccas_window.sv]
`default_nettype none
// Sliding neighborhood window over the padded raster stream, with line
// buffers between window rows and a registered match count.
module ccas_window #(
    parameter int GRID_WIDTH = 64,
    parameter int MAX_RANGE  = 3,
    parameter int STATE_BITS = 4,
    parameter int CNT_W      = 6
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire ccas_pkg::ccas_cfg_t   cfg,
    input  wire logic                  push,
    input  wire logic [STATE_BITS-1:0] din,
    input  wire logic                  calc,
    output logic                       out_valid,
    output logic      [STATE_BITS-1:0] out_state,
    output logic      [STATE_BITS-1:0] out_succ,
    output logic      [CNT_W-1:0]      out_count
);

    localparam int SPAN     = 2 * MAX_RANGE + 1;
    // ring depth plus the output register gives GRID_WIDTH-1 pushes of delay
    localparam int LB_DEPTH = GRID_WIDTH - 2;
    localparam int LBP_W    = $clog2(LB_DEPTH);
    localparam int RW       = $clog2(MAX_RANGE + 1);
    localparam int RC_W     = $clog2(SPAN + 1);
    localparam int NW       = STATE_BITS + 1;

    logic [STATE_BITS-1:0] q      [SPAN][SPAN];
    logic                  hit    [SPAN][SPAN];
    logic [STATE_BITS-1:0] row_in [SPAN];
    logic [STATE_BITS-1:0] lb_out [SPAN-1];
    logic [RC_W-1:0]       rc     [SPAN];
    logic [RC_W-1:0]       rc_reg [SPAN];
    logic [LBP_W-1:0]      lb_ptr_reg;
    logic [RW-1:0]         reff;
    logic [9:0]            n10;
    logic [NW-1:0]         n_eff;
    logic [NW-1:0]         succ_wide;
    logic [STATE_BITS-1:0] center;
    logic [STATE_BITS-1:0] succ;
    logic                  v_reg;
    logic [STATE_BITS-1:0] s_reg;
    logic [STATE_BITS-1:0] succ_reg;

    // effective radius and state count
    always_comb
    begin
        if (int'(cfg.range) > MAX_RANGE)
        begin
            reff = RW'(MAX_RANGE);
        end
        else
        begin
            reff = RW'(cfg.range);
        end
        if (cfg.count < 5'd2)
        begin
            n10 = 10'd2;
        end
        else if (10'(cfg.count) > 10'(1 << STATE_BITS))
        begin
            n10 = 10'(1 << STATE_BITS);
        end
        else
        begin
            n10 = 10'(cfg.count);
        end
        n_eff     = NW'(n10);
        center    = q[MAX_RANGE][MAX_RANGE];
        succ_wide = {1'b0, center} + NW'(1);
        succ      = (succ_wide >= n_eff) ? '0 : succ_wide[STATE_BITS-1:0];
    end

    assign row_in[0] = din;

    // shared ring pointer for all line buffers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lb_ptr_reg <= '0;
        end
        else if (push)
        begin
            lb_ptr_reg <= (lb_ptr_reg == LBP_W'(LB_DEPTH - 1)) ? '0 : lb_ptr_reg + LBP_W'(1);
        end
    end

    for (genvar ga = 0; ga < SPAN; ga++)
    begin : g_row
        if (ga > 0)
        begin : g_link
            assign row_in[ga] = lb_out[ga-1];
        end

        for (genvar gb = 0; gb < SPAN; gb++)
        begin : g_col
            localparam int AY = (MAX_RANGE > ga) ? MAX_RANGE - ga : ga - MAX_RANGE;
            localparam int AX = (MAX_RANGE > gb) ? MAX_RANGE - gb : gb - MAX_RANGE;
            logic en;
            logic [STATE_BITS-1:0] d;

            assign en = !(AX == 0 && AY == 0)
                     && ((RW+1)'(AX) <= {1'b0, reff})
                     && ((RW+1)'(AY) <= {1'b0, reff})
                     && (!cfg.kind || ((RW+1)'(AX + AY) <= {1'b0, reff}));

            if (gb == 0)
            begin : g_first
                assign d = row_in[ga];
            end
            else
            begin : g_next
                assign d = q[ga][gb-1];
            end

            ccas_cell #(
                .STATE_BITS(STATE_BITS)
            ) u_cell (
                .clk  (clk),
                .shift(push),
                .d    (d),
                .succ (succ),
                .en   (en),
                .q    (q[ga][gb]),
                .hit  (hit[ga][gb])
            );
        end

        // line buffer feeding the next window row: ring with registered read
        if (ga < SPAN - 1)
        begin : g_lb
            logic [STATE_BITS-1:0] lb [LB_DEPTH];
            logic [STATE_BITS-1:0] lb_q_reg;

            always_ff @(posedge clk)
            begin
                if (push)
                begin
                    lb[lb_ptr_reg] <= q[ga][SPAN-1];
                    lb_q_reg       <= lb[lb_ptr_reg];
                end
            end

            assign lb_out[ga] = lb_q_reg;
        end
    end

    always_comb
    begin
        for (int a = 0; a < SPAN; a++)
        begin
            rc[a] = '0;
            for (int b = 0; b < SPAN; b++)
            begin
                rc[a] = rc[a] + RC_W'(hit[a][b]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else
        begin
            v_reg <= calc;
        end
    end

    always_ff @(posedge clk)
    begin
        s_reg    <= center;
        succ_reg <= succ;
        for (int a = 0; a < SPAN; a++)
        begin
            rc_reg[a] <= rc[a];
        end
    end

    always_comb
    begin
        out_count = '0;
        for (int a = 0; a < SPAN; a++)
        begin
            out_count = out_count + CNT_W'(rc_reg[a]);
        end
    end

    assign out_valid = v_reg;
    assign out_state = s_reg;
    assign out_succ  = succ_reg;

endmodule
`default_nettype wire

[rtl/cyclic_cellular_automaton_step_top.sv]
`default_nettype none
// Write, read and no-op commands: result strobe in the cycle after the accept;
//   busy stays low, so one such transaction per cycle.
// Advance: the result strobe follows the last generation write, and the stream
//   makes one memory read per padded cell.
// Reset clears config to defaults and sweeps grid a to zero, one cell a cycle,
//   with busy high. Results cannot be stalled.
module cyclic_cellular_automaton_step_top #(
    parameter int GRID_WIDTH  = 64,
    parameter int GRID_HEIGHT = 64,
    parameter int MAX_RANGE   = 3,
    parameter int STATE_BITS  = 4
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    // command channel
    input  wire logic                            start,
    output logic                                 busy,
    input  wire logic [1:0]                      cmd,
    input  wire logic [5:0]                      col,
    input  wire logic [5:0]                      row,
    input  wire logic [3:0]                      cell_in,
    // result channel
    output logic                                 done,
    output logic      [3:0]                      cell_out,
    output logic      [1:0]                      done_kind,
    // configuration
    input  wire logic                            cfg_we,
    input  wire logic [1:0]                      cfg_addr,
    input  wire logic [ccas_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    localparam int CELLS  = GRID_WIDTH * GRID_HEIGHT;
    localparam int IW     = $clog2(CELLS);
    localparam int WP     = GRID_WIDTH + 2 * MAX_RANGE;
    localparam int HP     = GRID_HEIGHT + 2 * MAX_RANGE;
    localparam int XW     = $clog2(WP);
    localparam int YW     = $clog2(HP);
    localparam int CW     = $clog2(GRID_WIDTH);
    localparam int RWD    = $clog2(GRID_HEIGHT);
    localparam int CNT_W  = $clog2((2 * MAX_RANGE + 1) * (2 * MAX_RANGE + 1));
    localparam int TW     = (CNT_W > 6) ? CNT_W : 6;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RUN,
        ST_DRAIN
    } state_t;

    // wrap a 6-bit coordinate into the grid by repeated subtraction
    function automatic logic [10:0] wrap_coord(input logic [5:0] v, input int m);
        logic [10:0] t;
        t = 11'(v);
        for (int i = 0; i < 7; i++)
        begin
            if (int'(t) >= m)
            begin
                t = t - 11'(m);
            end
        end
        return t;
    endfunction

    state_t                 state_reg;
    logic                   bank_reg;       // 1: grid b is current
    logic [IW-1:0]          waddr_reg;
    logic [XW-1:0]          xx_reg;
    logic [YW-1:0]          yy_reg;
    logic [CW-1:0]          scol_reg;
    logic [RWD-1:0]         srow_reg;
    logic                   rv_reg;
    logic                   cv1_reg;
    logic                   cv2_reg;
    logic                   done_reg;
    logic                   done_next;
    ccas_pkg::ccas_cmd_t    kind_reg;
    logic                   out_rd_reg;
    ccas_pkg::ccas_cfg_t    cfg_reg;

    logic [STATE_BITS-1:0]  mem [2][CELLS];
    logic [STATE_BITS-1:0]  rdata_reg;

    ccas_pkg::ccas_cmd_t    cmd_code;
    logic                   accept;
    logic [CW-1:0]          col_w;
    logic [RWD-1:0]         row_w;
    logic [IW-1:0]          cmd_idx;
    logic [IW-1:0]          stream_idx;
    logic                   center_ok;
    logic                   last_issue;

    logic                   we;
    logic                   wbank;
    logic [IW-1:0]          widx;
    logic [STATE_BITS-1:0]  wdata;
    logic [IW-1:0]          ridx;

    logic                   win_valid;
    logic [STATE_BITS-1:0]  win_state;
    logic [STATE_BITS-1:0]  win_succ;
    logic [CNT_W-1:0]       win_count;
    logic [STATE_BITS-1:0]  new_state;

    assign cmd_code   = ccas_pkg::ccas_cmd_t'(cmd);
    assign busy       = (state_reg != ST_IDLE);
    assign accept     = start && !busy;

    assign col_w      = CW'(wrap_coord(col, GRID_WIDTH));
    assign row_w      = RWD'(wrap_coord(row, GRID_HEIGHT));
    assign cmd_idx    = IW'(int'(row_w) * GRID_WIDTH + int'(col_w));
    assign stream_idx = IW'(int'(srow_reg) * GRID_WIDTH + int'(scol_reg));

    // window is full once 2*MAX_RANGE padded rows and columns have streamed in
    assign center_ok  = (yy_reg >= YW'(2 * MAX_RANGE)) && (xx_reg >= XW'(2 * MAX_RANGE));
    assign last_issue = (yy_reg == YW'(HP - 1)) && (xx_reg == XW'(WP - 1));

    assign new_state  = (TW'(win_count) >= TW'(cfg_reg.threshold)) ? win_succ : win_state;

    // strobe for an immediate command, or for the last generation write
    assign done_next  = (state_reg == ST_IDLE && start && cmd_code != ccas_pkg::CMD_ADVANCE)
                     || (state_reg == ST_DRAIN && win_valid && waddr_reg == IW'(CELLS - 1));

    // configuration writes, taken in any state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.range     <= 2'd1;
            cfg_reg.threshold <= 6'd1;
            cfg_reg.count     <= 5'd8;
            cfg_reg.kind      <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (ccas_pkg::ccas_reg_t'(cfg_addr))
                ccas_pkg::REG_RANGE:     cfg_reg.range     <= cfg_wdata[1:0];
                ccas_pkg::REG_THRESHOLD: cfg_reg.threshold <= cfg_wdata[5:0];
                ccas_pkg::REG_COUNT:     cfg_reg.count     <= cfg_wdata[4:0];
                ccas_pkg::REG_KIND:      cfg_reg.kind      <= cfg_wdata[0];
                default:                 cfg_reg.kind      <= cfg_reg.kind;
            endcase
        end
    end

    // memory port selection: clear sweep, command write, or generation write
    always_comb
    begin
        we    = 1'b0;
        wbank = bank_reg;
        widx  = waddr_reg;
        wdata = '0;
        ridx  = cmd_idx;
        unique case (state_reg)
            ST_CLEAR:
            begin
                we    = 1'b1;
                wbank = 1'b0;
            end
            ST_IDLE:
            begin
                we    = accept && (cmd_code == ccas_pkg::CMD_WRITE);
                widx  = cmd_idx;
                wdata = STATE_BITS'(cell_in);
            end
            ST_RUN, ST_DRAIN:
            begin
                we    = win_valid;
                wbank = !bank_reg;
                wdata = new_state;
                ridx  = stream_idx;
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    // grid a and grid b, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wbank][widx] <= wdata;
        end
        rdata_reg <= mem[bank_reg][ridx];
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            bank_reg   <= 1'b0;
            waddr_reg  <= '0;
            xx_reg     <= '0;
            yy_reg     <= '0;
            scol_reg   <= '0;
            srow_reg   <= '0;
            rv_reg     <= 1'b0;
            cv1_reg    <= 1'b0;
            cv2_reg    <= 1'b0;
            done_reg   <= 1'b0;
            kind_reg   <= ccas_pkg::CMD_WRITE;
            out_rd_reg <= 1'b0;
        end
        else
        begin
            done_reg <= done_next;
            rv_reg   <= (state_reg == ST_RUN);
            cv1_reg  <= (state_reg == ST_RUN) && center_ok;
            cv2_reg  <= cv1_reg;
            unique case (state_reg)
                ST_CLEAR:
                begin
                    if (waddr_reg == IW'(CELLS - 1))
                    begin
                        waddr_reg <= '0;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        waddr_reg <= waddr_reg + IW'(1);
                    end
                end
                ST_IDLE:
                begin
                    if (start)
                    begin
                        kind_reg   <= cmd_code;
                        out_rd_reg <= (cmd_code == ccas_pkg::CMD_READ);
                        if (cmd_code == ccas_pkg::CMD_ADVANCE)
                        begin
                            // stream starts MAX_RANGE rows/cols before the origin
                            state_reg <= ST_RUN;
                            waddr_reg <= '0;
                            xx_reg    <= '0;
                            yy_reg    <= '0;
                            scol_reg  <= CW'(GRID_WIDTH - MAX_RANGE);
                            srow_reg  <= RWD'(GRID_HEIGHT - MAX_RANGE);
                        end
                    end
                end
                ST_RUN:
                begin
                    if (xx_reg == XW'(WP - 1))
                    begin
                        xx_reg   <= '0;
                        yy_reg   <= yy_reg + YW'(1);
                        scol_reg <= CW'(GRID_WIDTH - MAX_RANGE);
                        srow_reg <= (srow_reg == RWD'(GRID_HEIGHT - 1)) ?
                                    '0 : srow_reg + RWD'(1);
                    end
                    else
                    begin
                        xx_reg   <= xx_reg + XW'(1);
                        scol_reg <= (scol_reg == CW'(GRID_WIDTH - 1)) ?
                                    '0 : scol_reg + CW'(1);
                    end
                    if (last_issue)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                    // the last result always lands after the last issue
                    if (win_valid)
                    begin
                        waddr_reg <= waddr_reg + IW'(1);
                    end
                end
                ST_DRAIN:
                begin
                    // generation results land in raster order; last one flips the grids
                    if (win_valid)
                    begin
                        if (waddr_reg == IW'(CELLS - 1))
                        begin
                            waddr_reg <= '0;
                            bank_reg  <= !bank_reg;
                            state_reg <= ST_IDLE;
                        end
                        else
                        begin
                            waddr_reg <= waddr_reg + IW'(1);
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    ccas_window #(
        .GRID_WIDTH(GRID_WIDTH),
        .MAX_RANGE (MAX_RANGE),
        .STATE_BITS(STATE_BITS),
        .CNT_W     (CNT_W)
    ) u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .push     (rv_reg),
        .din      (rdata_reg),
        .calc     (cv2_reg),
        .out_valid(win_valid),
        .out_state(win_state),
        .out_succ (win_succ),
        .out_count(win_count)
    );

    // read data stays in the read register during the result cycle
    assign done      = done_reg;
    assign done_kind = kind_reg;
    assign cell_out  = out_rd_reg ? 4'(rdata_reg) : 4'd0;

endmodule
`default_nettype wire
